// ===== src/lsc_pkg.sv =====
// Shared constants, codes and state types of the line segment clipper.
package lsc_pkg;

    localparam int LSC_COORD_WIDTH = 16;
    // Bits needed to hold the reset window values as signed numbers.
    localparam int LSC_RESET_WIDTH = 10;
    localparam int LSC_MAX_ROUNDS = 4;
    localparam int LSC_ROUND_WIDTH = $clog2(LSC_MAX_ROUNDS + 1);
    localparam int LSC_INDEX_WIDTH = 2;

    localparam int WIN_LEFT_RESET = 200;
    localparam int WIN_RIGHT_RESET = 350;
    localparam int WIN_BOTTOM_RESET = 200;
    localparam int WIN_TOP_RESET = 350;

    typedef enum logic [LSC_INDEX_WIDTH-1:0] {
        REG_WIN_LEFT,
        REG_WIN_RIGHT,
        REG_WIN_BOTTOM,
        REG_WIN_TOP
    } cfg_index_t;

    // Bit positions inside an outcode.
    localparam int OC_LEFT = 0;
    localparam int OC_RIGHT = 1;
    localparam int OC_BOTTOM = 2;
    localparam int OC_TOP = 3;

    typedef logic [3:0] outcode_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_CODE,
        SEQ_TEST,
        SEQ_ISSUE,
        SEQ_WAIT,
        SEQ_DONE
    } seq_state_t;

    typedef enum logic [2:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV,
        MD_ROUND,
        MD_DONE
    } md_state_t;

    // Window registers must hold both the coordinates and the reset values.
    function automatic int win_width(input int coord_width);
        return (coord_width > LSC_RESET_WIDTH) ? coord_width : LSC_RESET_WIDTH;
    endfunction

endpackage

// ===== src/lsc_if.sv =====
// Request channels of the clipper: segment in, clipped result out.
interface lsc_seg_if #(
    parameter int COORD_WIDTH = lsc_pkg::LSC_COORD_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] start_x;
    logic signed [COORD_WIDTH-1:0] start_y;
    logic signed [COORD_WIDTH-1:0] end_x;
    logic signed [COORD_WIDTH-1:0] end_y;

    modport source (output valid, output start_x, output start_y, output end_x,
                    output end_y, input ready);
    modport sink (input valid, input start_x, input start_y, input end_x,
                  input end_y, output ready);
endinterface

interface lsc_res_if #(
    parameter int COORD_WIDTH = lsc_pkg::LSC_COORD_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic                          accepted;
    logic signed [COORD_WIDTH-1:0] clip_start_x;
    logic signed [COORD_WIDTH-1:0] clip_start_y;
    logic signed [COORD_WIDTH-1:0] clip_end_x;
    logic signed [COORD_WIDTH-1:0] clip_end_y;

    modport source (output valid, output accepted, output clip_start_x,
                    output clip_start_y, output clip_end_x, output clip_end_y,
                    input ready);
    modport sink (input valid, input accepted, input clip_start_x,
                  input clip_start_y, input clip_end_x, input clip_end_y,
                  output ready);
endinterface

// ===== src/line_segment_clipper.sv =====
// Cohen-Sutherland line segment clipper against a programmable window.
// A trivial accept or reject needs no edge move; any other segment gets up to LSC_MAX_ROUNDS edge
// moves, each one multiply and a one-bit-per-cycle divide in the shared unit, which
// works at WinWidth: COORD_WIDTH but at least 10 bits. One segment at a time; the next
// request is taken in the cycle after the result is loaded into the output register.
// Reset clears control state and loads the window with left 200, right 350, bottom 200, top 350.
module line_segment_clipper #(
    parameter int COORD_WIDTH = lsc_pkg::LSC_COORD_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    lsc_seg_if.sink                             segment,
    lsc_res_if.source                           result,
    input  logic                                wr_en,
    input  logic [lsc_pkg::LSC_INDEX_WIDTH-1:0] wr_index,
    input  logic [COORD_WIDTH-1:0]              wr_data
);
    import lsc_pkg::*;

    localparam int WinWidth = win_width(COORD_WIDTH);

    logic signed [WinWidth-1:0] win_left, win_right, win_bottom, win_top;
    logic                       md_start, md_done;
    logic signed [WinWidth:0]   op_a, op_b, op_c, md_quot;

    lsc_regs #(
        .COORD_WIDTH (COORD_WIDTH),
        .WIN_WIDTH   (WinWidth)
    ) u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .win_left   (win_left),
        .win_right  (win_right),
        .win_bottom (win_bottom),
        .win_top    (win_top)
    );

    lsc_muldiv #(
        .COORD_WIDTH (WinWidth)
    ) u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (md_start),
        .op_a  (op_a),
        .op_b  (op_b),
        .op_c  (op_c),
        .done  (md_done),
        .quot  (md_quot)
    );

    lsc_seq #(
        .COORD_WIDTH (COORD_WIDTH),
        .WIN_WIDTH   (WinWidth)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .segment    (segment),
        .result     (result),
        .win_left   (win_left),
        .win_right  (win_right),
        .win_bottom (win_bottom),
        .win_top    (win_top),
        .md_start   (md_start),
        .op_a       (op_a),
        .op_b       (op_b),
        .op_c       (op_c),
        .md_done    (md_done),
        .md_quot    (md_quot)
    );

    // A rejected segment always reports zero endpoints.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.accepted |->
            result.clip_start_x == '0 && result.clip_start_y == '0 &&
            result.clip_end_x == '0 && result.clip_end_y == '0)
        else $error("rejected result carries nonzero endpoints");

    // Only one segment is in flight at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        segment.valid && segment.ready |=> !segment.ready)
        else $error("request taken while a segment is in work");

    // A result cannot appear in the cycle right after a request is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        segment.valid && segment.ready |=> !$rose(result.valid))
        else $error("result appeared too early");

    // The shared unit is only started while the previous operation is finished.
    assert property (@(posedge clk) disable iff (!rst_n)
        md_start |=> !md_start && !md_done)
        else $error("shared unit started twice in a row");

endmodule

// ===== src/lsc_regs.sv =====
// Window boundary registers written through the configuration port.
module lsc_regs #(
    parameter int COORD_WIDTH = lsc_pkg::LSC_COORD_WIDTH,
    parameter int WIN_WIDTH = lsc_pkg::win_width(lsc_pkg::LSC_COORD_WIDTH)
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  wr_en,
    input  logic [lsc_pkg::LSC_INDEX_WIDTH-1:0]   wr_index,
    input  logic [COORD_WIDTH-1:0]                wr_data,
    output logic signed [WIN_WIDTH-1:0]           win_left,
    output logic signed [WIN_WIDTH-1:0]           win_right,
    output logic signed [WIN_WIDTH-1:0]           win_bottom,
    output logic signed [WIN_WIDTH-1:0]           win_top
);
    import lsc_pkg::*;

    logic signed [WIN_WIDTH-1:0] left_reg, left_next;
    logic signed [WIN_WIDTH-1:0] right_reg, right_next;
    logic signed [WIN_WIDTH-1:0] bottom_reg, bottom_next;
    logic signed [WIN_WIDTH-1:0] top_reg, top_next;
    logic signed [WIN_WIDTH-1:0] data_ext;

    always_comb
    begin
        data_ext    = WIN_WIDTH'(signed'(wr_data));
        left_next   = left_reg;
        right_next  = right_reg;
        bottom_next = bottom_reg;
        top_next    = top_reg;
        if (wr_en)
        begin
            unique case (cfg_index_t'(wr_index))
                REG_WIN_LEFT:   left_next = data_ext;
                REG_WIN_RIGHT:  right_next = data_ext;
                REG_WIN_BOTTOM: bottom_next = data_ext;
                REG_WIN_TOP:    top_next = data_ext;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= WIN_WIDTH'(WIN_LEFT_RESET);
            right_reg  <= WIN_WIDTH'(WIN_RIGHT_RESET);
            bottom_reg <= WIN_WIDTH'(WIN_BOTTOM_RESET);
            top_reg    <= WIN_WIDTH'(WIN_TOP_RESET);
        end
        else
        begin
            left_reg   <= left_next;
            right_reg  <= right_next;
            bottom_reg <= bottom_next;
            top_reg    <= top_next;
        end
    end

    assign win_left   = left_reg;
    assign win_right  = right_reg;
    assign win_bottom = bottom_reg;
    assign win_top    = top_reg;

endmodule

// ===== src/lsc_muldiv.sv =====
// Shared unit that forms round(a * b / c) with one multiply and a bit-serial divide.
module lsc_muldiv #(
    parameter int COORD_WIDTH = lsc_pkg::LSC_COORD_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [COORD_WIDTH:0]  op_a,
    input  logic signed [COORD_WIDTH:0]  op_b,
    input  logic signed [COORD_WIDTH:0]  op_c,
    output logic                         done,
    output logic signed [COORD_WIDTH:0]  quot
);
    import lsc_pkg::*;

    localparam int W = COORD_WIDTH;
    localparam int CntWidth = $clog2(COORD_WIDTH);

    md_state_t state_reg, state_next;
    logic [CntWidth-1:0] cnt_reg, cnt_next;
    logic [W-1:0] mag_a_reg, mag_a_next;
    logic [W-1:0] mag_b_reg, mag_b_next;
    logic [W-1:0] mag_c_reg, mag_c_next;
    logic         neg_reg, neg_next;
    logic [W-1:0] rem_reg, rem_next;
    logic [W-1:0] quo_reg, quo_next;
    logic signed [W:0] quot_reg, quot_next;

    logic signed [W:0] neg_a, neg_b, neg_c;
    logic [2*W-1:0]    product;
    logic [W:0]        divisor, trial, diff, rounded;
    logic              fits, round_up;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        mag_a_next = mag_a_reg;
        mag_b_next = mag_b_reg;
        mag_c_next = mag_c_reg;
        neg_next   = neg_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        quot_next  = quot_reg;

        neg_a    = -op_a;
        neg_b    = -op_b;
        neg_c    = -op_c;
        product  = mag_a_reg * mag_b_reg;
        divisor  = {1'b0, mag_c_reg};
        trial    = {rem_reg, quo_reg[W-1]};
        diff     = trial - divisor;
        fits     = (trial >= divisor);
        round_up = ({rem_reg, 1'b0} >= divisor);
        rounded  = {1'b0, quo_reg} + (W+1)'(round_up);

        unique case (state_reg)
            MD_IDLE:
            begin
                if (start)
                begin
                    mag_a_next = op_a[W] ? neg_a[W-1:0] : op_a[W-1:0];
                    mag_b_next = op_b[W] ? neg_b[W-1:0] : op_b[W-1:0];
                    mag_c_next = op_c[W] ? neg_c[W-1:0] : op_c[W-1:0];
                    neg_next   = op_a[W] ^ op_b[W] ^ op_c[W];
                    state_next = MD_MUL;
                end
            end
            MD_MUL:
            begin
                // The quotient never exceeds |a|, so the upper half of the
                // product is already a valid partial remainder.
                rem_next   = product[2*W-1:W];
                quo_next   = product[W-1:0];
                cnt_next   = CntWidth'(W - 1);
                state_next = MD_DIV;
            end
            MD_DIV:
            begin
                rem_next = fits ? diff[W-1:0] : trial[W-1:0];
                quo_next = {quo_reg[W-2:0], fits};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = MD_ROUND;
                end
            end
            MD_ROUND:
            begin
                // Half or more of the divisor left over rounds the magnitude up.
                quot_next  = neg_reg ? -signed'(rounded) : signed'(rounded);
                state_next = MD_DONE;
            end
            MD_DONE:
            begin
                state_next = MD_IDLE;
            end
            default:
            begin
                state_next = MD_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_a_reg <= mag_a_next;
        mag_b_reg <= mag_b_next;
        mag_c_reg <= mag_c_next;
        neg_reg   <= neg_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        quot_reg  <= quot_next;
    end

    assign done = (state_reg == MD_DONE);
    assign quot = quot_reg;

endmodule

// ===== src/lsc_seq.sv =====
// Clipping sequencer: outcodes, trivial accept and reject, edge moves, result register.
module lsc_seq #(
    parameter int COORD_WIDTH = lsc_pkg::LSC_COORD_WIDTH,
    parameter int WIN_WIDTH = lsc_pkg::win_width(lsc_pkg::LSC_COORD_WIDTH)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    lsc_seg_if.sink                      segment,
    lsc_res_if.source                    result,
    input  logic signed [WIN_WIDTH-1:0]  win_left,
    input  logic signed [WIN_WIDTH-1:0]  win_right,
    input  logic signed [WIN_WIDTH-1:0]  win_bottom,
    input  logic signed [WIN_WIDTH-1:0]  win_top,
    output logic                         md_start,
    output logic signed [WIN_WIDTH:0]    op_a,
    output logic signed [WIN_WIDTH:0]    op_b,
    output logic signed [WIN_WIDTH:0]    op_c,
    input  logic                         md_done,
    input  logic signed [WIN_WIDTH:0]    md_quot
);
    import lsc_pkg::*;

    // Working coordinates are as wide as the window, since a point can be moved onto
    // a reset edge that lies outside the coordinate range.
    localparam int W = WIN_WIDTH;

    seq_state_t state_reg, state_next;
    logic [LSC_ROUND_WIDTH-1:0] round_reg, round_next;
    logic signed [W-1:0] x1_reg, x1_next, y1_reg, y1_next;
    logic signed [W-1:0] x2_reg, x2_next, y2_reg, y2_next;
    outcode_t c1_reg, c1_next, c2_reg, c2_next;
    logic     acc_reg, acc_next;
    logic     move1_reg, move1_next;
    logic     edge_is_y_reg, edge_is_y_next;
    logic signed [W-1:0] edge_reg, edge_next;
    logic signed [W:0] op_a_reg, op_a_next, op_b_reg, op_b_next, op_c_reg, op_c_next;
    logic     out_valid_reg, out_valid_next;
    logic     out_acc_reg, out_acc_next;
    logic signed [W-1:0] out_x1_reg, out_x1_next, out_y1_reg, out_y1_next;
    logic signed [W-1:0] out_x2_reg, out_x2_next, out_y2_reg, out_y2_next;

    logic signed [WIN_WIDTH-1:0] x1_w, y1_w, x2_w, y2_w;
    logic signed [W:0] x1_e, y1_e, x2_e, y2_e, dx, dy, base_e, sum;
    logic signed [W-1:0] left_n, right_n, bottom_n, top_n;
    outcode_t code1, code2, co;
    logic     load_out;

    assign x1_w = x1_reg;
    assign y1_w = y1_reg;
    assign x2_w = x2_reg;
    assign y2_w = y2_reg;
    assign x1_e = x1_reg;
    assign y1_e = y1_reg;
    assign x2_e = x2_reg;
    assign y2_e = y2_reg;

    assign left_n   = win_left;
    assign right_n  = win_right;
    assign bottom_n = win_bottom;
    assign top_n    = win_top;

    always_comb
    begin
        code1[OC_LEFT]   = (x1_w < win_left);
        code1[OC_RIGHT]  = (x1_w > win_right);
        code1[OC_BOTTOM] = (y1_w < win_bottom);
        code1[OC_TOP]    = (y1_w > win_top);
        code2[OC_LEFT]   = (x2_w < win_left);
        code2[OC_RIGHT]  = (x2_w > win_right);
        code2[OC_BOTTOM] = (y2_w < win_bottom);
        code2[OC_TOP]    = (y2_w > win_top);
    end

    always_comb
    begin
        state_next     = state_reg;
        round_next     = round_reg;
        x1_next        = x1_reg;
        y1_next        = y1_reg;
        x2_next        = x2_reg;
        y2_next        = y2_reg;
        c1_next        = c1_reg;
        c2_next        = c2_reg;
        acc_next       = acc_reg;
        move1_next     = move1_reg;
        edge_is_y_next = edge_is_y_reg;
        edge_next      = edge_reg;
        op_a_next      = op_a_reg;
        op_b_next      = op_b_reg;
        op_c_next      = op_c_reg;
        out_acc_next   = out_acc_reg;
        out_x1_next    = out_x1_reg;
        out_y1_next    = out_y1_reg;
        out_x2_next    = out_x2_reg;
        out_y2_next    = out_y2_reg;
        md_start       = 1'b0;
        load_out       = 1'b0;

        co     = (c1_reg != '0) ? c1_reg : c2_reg;
        dx     = x2_e - x1_e;
        dy     = y2_e - y1_e;
        base_e = edge_is_y_reg ? x1_e : y1_e;
        sum    = base_e + md_quot;

        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (segment.valid)
                begin
                    x1_next    = W'(segment.start_x);
                    y1_next    = W'(segment.start_y);
                    x2_next    = W'(segment.end_x);
                    y2_next    = W'(segment.end_y);
                    round_next = '0;
                    state_next = SEQ_CODE;
                end
            end
            SEQ_CODE:
            begin
                c1_next    = code1;
                c2_next    = code2;
                state_next = SEQ_TEST;
            end
            SEQ_TEST:
            begin
                priority if ((c1_reg | c2_reg) == '0)
                begin
                    acc_next   = 1'b1;
                    state_next = SEQ_DONE;
                end
                else if ((c1_reg & c2_reg) != '0)
                begin
                    acc_next   = 1'b0;
                    state_next = SEQ_DONE;
                end
                else if (round_reg == LSC_ROUND_WIDTH'(LSC_MAX_ROUNDS))
                begin
                    acc_next   = 1'b0;
                    state_next = SEQ_DONE;
                end
                else
                begin
                    move1_next = (c1_reg != '0);
                    round_next = round_reg + 1'b1;
                    state_next = SEQ_ISSUE;
                    // Top first, then bottom, right and left.
                    priority if (co[OC_TOP])
                    begin
                        edge_is_y_next = 1'b1;
                        edge_next      = top_n;
                        op_a_next      = dx;
                        op_b_next      = (W+1)'(top_n) - y1_e;
                        op_c_next      = dy;
                    end
                    else if (co[OC_BOTTOM])
                    begin
                        edge_is_y_next = 1'b1;
                        edge_next      = bottom_n;
                        op_a_next      = dx;
                        op_b_next      = (W+1)'(bottom_n) - y1_e;
                        op_c_next      = dy;
                    end
                    else if (co[OC_RIGHT])
                    begin
                        edge_is_y_next = 1'b0;
                        edge_next      = right_n;
                        op_a_next      = dy;
                        op_b_next      = (W+1)'(right_n) - x1_e;
                        op_c_next      = dx;
                    end
                    else
                    begin
                        edge_is_y_next = 1'b0;
                        edge_next      = left_n;
                        op_a_next      = dy;
                        op_b_next      = (W+1)'(left_n) - x1_e;
                        op_c_next      = dx;
                    end
                end
            end
            SEQ_ISSUE:
            begin
                md_start   = 1'b1;
                state_next = SEQ_WAIT;
            end
            SEQ_WAIT:
            begin
                if (md_done)
                begin
                    state_next = SEQ_CODE;
                    if (move1_reg)
                    begin
                        x1_next = edge_is_y_reg ? sum[W-1:0] : edge_reg;
                        y1_next = edge_is_y_reg ? edge_reg : sum[W-1:0];
                    end
                    else
                    begin
                        x2_next = edge_is_y_reg ? sum[W-1:0] : edge_reg;
                        y2_next = edge_is_y_reg ? edge_reg : sum[W-1:0];
                    end
                end
            end
            SEQ_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    load_out     = 1'b1;
                    out_acc_next = acc_reg;
                    out_x1_next  = acc_reg ? x1_reg : '0;
                    out_y1_next  = acc_reg ? y1_reg : '0;
                    out_x2_next  = acc_reg ? x2_reg : '0;
                    out_y2_next  = acc_reg ? y2_reg : '0;
                    state_next   = SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SEQ_IDLE;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x1_reg        <= x1_next;
        y1_reg        <= y1_next;
        x2_reg        <= x2_next;
        y2_reg        <= y2_next;
        c1_reg        <= c1_next;
        c2_reg        <= c2_next;
        acc_reg       <= acc_next;
        move1_reg     <= move1_next;
        edge_is_y_reg <= edge_is_y_next;
        edge_reg      <= edge_next;
        op_a_reg      <= op_a_next;
        op_b_reg      <= op_b_next;
        op_c_reg      <= op_c_next;
        out_acc_reg   <= out_acc_next;
        out_x1_reg    <= out_x1_next;
        out_y1_reg    <= out_y1_next;
        out_x2_reg    <= out_x2_next;
        out_y2_reg    <= out_y2_next;
    end

    assign segment.ready       = (state_reg == SEQ_IDLE);
    assign result.valid        = out_valid_reg;
    assign result.accepted     = out_acc_reg;
    assign result.clip_start_x = out_x1_reg[COORD_WIDTH-1:0];
    assign result.clip_start_y = out_y1_reg[COORD_WIDTH-1:0];
    assign result.clip_end_x   = out_x2_reg[COORD_WIDTH-1:0];
    assign result.clip_end_y   = out_y2_reg[COORD_WIDTH-1:0];
    assign op_a                = op_a_reg;
    assign op_b                = op_b_reg;
    assign op_c                = op_c_reg;

endmodule

// ===== tb/line_segment_clipper_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the line segment clipper: directed and random segments, several windows.
module line_segment_clipper_test;
    import lsc_pkg::*;

    localparam int W = LSC_COORD_WIDTH;
    localparam int COORD_MIN = -(1 << (W - 1));
    localparam int COORD_MAX = (1 << (W - 1)) - 1;
    localparam int CYCLE_LIMIT = 1000000;
    // Outlasts the longest clip: every allowed edge move plus the final trivial test.
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic signed [W-1:0] sx;
        logic signed [W-1:0] sy;
        logic signed [W-1:0] ex;
        logic signed [W-1:0] ey;
    } segment_t;

    typedef struct {
        logic                accepted;
        logic signed [W-1:0] sx;
        logic signed [W-1:0] sy;
        logic signed [W-1:0] ex;
        logic signed [W-1:0] ey;
    } clip_t;

    logic                       clk;
    logic                       rst_n;
    logic                       wr_en;
    logic [LSC_INDEX_WIDTH-1:0] wr_index;
    logic [W-1:0]               wr_data;

    lsc_seg_if #(.COORD_WIDTH(W)) seg_if ();
    lsc_res_if #(.COORD_WIDTH(W)) res_if ();

    line_segment_clipper #(.COORD_WIDTH(W)) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .segment  (seg_if),
        .result   (res_if),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // Window as the block should hold it.
    logic signed [W-1:0] window_left = WIN_LEFT_RESET;
    logic signed [W-1:0] window_right = WIN_RIGHT_RESET;
    logic signed [W-1:0] window_bottom = WIN_BOTTOM_RESET;
    logic signed [W-1:0] window_top = WIN_TOP_RESET;

    clip_t pending_clips[$];
    int    failures = 0;
    int    segments_sent = 0;
    int    clips_checked = 0;
    int    window_settings = 0;
    int    hold_requests = 0;
    int    cycle_count = 0;
    bit    src_idling = 1'b1;
    bit    sink_idling = 1'b1;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic outcode_t region_code(input longint x, input longint y);
        outcode_t c;
        c = '0;
        if (x < longint'(window_left))
            c[OC_LEFT] = 1'b1;
        if (x > longint'(window_right))
            c[OC_RIGHT] = 1'b1;
        if (y < longint'(window_bottom))
            c[OC_BOTTOM] = 1'b1;
        if (y > longint'(window_top))
            c[OC_TOP] = 1'b1;
        return c;
    endfunction

    // a * b / c rounded to nearest, ties away from zero; a zero divisor gives 0.
    function automatic longint scaled_offset(input longint a, input longint b, input longint c);
        longint ua;
        longint ub;
        longint uc;
        longint prod;
        longint quo;
        longint rem;
        bit     neg;
        if (c == 0)
            return 0;
        neg = (a < 0) ^ (b < 0) ^ (c < 0);
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        uc = (c < 0) ? -c : c;
        prod = ua * ub;
        quo = prod / uc;
        rem = prod - quo * uc;
        if (rem >= uc - rem)
            quo++;
        return neg ? -quo : quo;
    endfunction

    function automatic clip_t predict_clip(input segment_t s);
        longint   x1;
        longint   y1;
        longint   x2;
        longint   y2;
        longint   nx;
        longint   ny;
        outcode_t c1;
        outcode_t c2;
        outcode_t co;
        int       moves;
        bit       done;
        clip_t    r;
        x1 = s.sx;
        y1 = s.sy;
        x2 = s.ex;
        y2 = s.ey;
        c1 = region_code(x1, y1);
        c2 = region_code(x2, y2);
        r = '{accepted: 1'b0, sx: '0, sy: '0, ex: '0, ey: '0};
        moves = 0;
        done = 1'b0;
        while (!done)
        begin
            if ((c1 | c2) == '0)
            begin
                r.accepted = 1'b1;
                done = 1'b1;
            end
            else if ((c1 & c2) != '0)
                done = 1'b1;
            else if (moves >= LSC_MAX_ROUNDS)
                done = 1'b1;
            else
            begin
                co = (c1 != '0) ? c1 : c2;
                // The intersection is always taken from the first endpoint.
                if (co[OC_TOP])
                begin
                    nx = x1 + scaled_offset(x2 - x1, longint'(window_top) - y1, y2 - y1);
                    ny = window_top;
                end
                else if (co[OC_BOTTOM])
                begin
                    nx = x1 + scaled_offset(x2 - x1, longint'(window_bottom) - y1, y2 - y1);
                    ny = window_bottom;
                end
                else if (co[OC_RIGHT])
                begin
                    ny = y1 + scaled_offset(y2 - y1, longint'(window_right) - x1, x2 - x1);
                    nx = window_right;
                end
                else
                begin
                    ny = y1 + scaled_offset(y2 - y1, longint'(window_left) - x1, x2 - x1);
                    nx = window_left;
                end
                if (c1 != '0)
                begin
                    x1 = nx;
                    y1 = ny;
                    c1 = region_code(x1, y1);
                end
                else
                begin
                    x2 = nx;
                    y2 = ny;
                    c2 = region_code(x2, y2);
                end
                moves++;
            end
        end
        if (r.accepted)
        begin
            r.sx = x1[W-1:0];
            r.sy = y1[W-1:0];
            r.ex = x2[W-1:0];
            r.ey = y2[W-1:0];
        end
        return r;
    endfunction

    task automatic offer_segment(input int sx, input int sy, input int ex, input int ey);
        segment_t s;
        int       gap;
        s.sx = sx[W-1:0];
        s.sy = sy[W-1:0];
        s.ex = ex[W-1:0];
        s.ey = ey[W-1:0];
        if (src_idling && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 9);
            seg_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        seg_if.valid <= 1'b1;
        seg_if.start_x <= s.sx;
        seg_if.start_y <= s.sy;
        seg_if.end_x <= s.ex;
        seg_if.end_y <= s.ey;
        do
            @(posedge clk);
        while (!seg_if.ready);
        pending_clips.push_back(predict_clip(s));
        segments_sent++;
    endtask

    // Drop the request and wait until every clip has come back.
    task automatic settle_block();
        seg_if.valid <= 1'b0;
        while (pending_clips.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input int val);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val[W-1:0];
        @(posedge clk);
        case (idx)
            REG_WIN_LEFT:   window_left = val[W-1:0];
            REG_WIN_RIGHT:  window_right = val[W-1:0];
            REG_WIN_BOTTOM: window_bottom = val[W-1:0];
            REG_WIN_TOP:    window_top = val[W-1:0];
            default:        ;
        endcase
    endtask

    task automatic set_window(input int l, input int r, input int b, input int t);
        settle_block();
        write_reg(REG_WIN_LEFT, l);
        write_reg(REG_WIN_RIGHT, r);
        write_reg(REG_WIN_BOTTOM, b);
        write_reg(REG_WIN_TOP, t);
        wr_en <= 1'b0;
        window_settings++;
    endtask

    function automatic int random_coord();
        return int'($urandom_range(0, (1 << W) - 1)) + COORD_MIN;
    endfunction

    // Mostly near the window span, sometimes right on an edge, sometimes anywhere.
    function automatic int pick_coord(input int lo, input int hi);
        int a;
        int b;
        int span;
        int v;
        a = (lo < hi) ? lo : hi;
        b = (lo < hi) ? hi : lo;
        span = (b - a) + 16;
        case ($urandom_range(0, 7))
            0, 1:    v = random_coord();
            2:       v = ($urandom_range(0, 1) ? a : b) + int'($urandom_range(0, 2)) - 1;
            default: v = a - span + int'($urandom_range(0, b - a + 2 * span));
        endcase
        if (v < COORD_MIN)
            v = COORD_MIN;
        if (v > COORD_MAX)
            v = COORD_MAX;
        return v;
    endfunction

    task automatic random_segments(input int count, input int l, input int r, input int b,
                                   input int t);
        int sx;
        int sy;
        int ex;
        int ey;
        repeat (count)
        begin
            sx = pick_coord(l, r);
            sy = pick_coord(b, t);
            ex = pick_coord(l, r);
            ey = pick_coord(b, t);
            // Now and then a vertical or horizontal segment.
            case ($urandom_range(0, 9))
                0:       ex = sx;
                1:       ey = sy;
                default: ;
            endcase
            offer_segment(sx, sy, ex, ey);
        end
    endtask

    task automatic test_reset_window();
        offer_segment(250, 250, 300, 300);
        offer_segment(0, 250, 100, 300);
        offer_segment(275, 400, 275, 300);
        offer_segment(275, 100, 275, 300);
        offer_segment(400, 275, 300, 275);
        offer_segment(100, 275, 300, 275);
        offer_segment(0, 0, 500, 500);
        offer_segment(0, 300, 300, 600);
        // Halfway intersections that round away from zero both ways.
        offer_segment(199, 250, 201, 251);
        offer_segment(199, 250, 201, 249);
        offer_segment(275, 275, 275, 275);
        offer_segment(0, 0, 0, 0);
        offer_segment(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
        offer_segment(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
        offer_segment(200, 200, 350, 350);
        offer_segment(199, 200, 199, 350);
    endtask

    task automatic test_window_extremes();
        set_window(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
        offer_segment(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
        offer_segment(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
        set_window(0, 0, 0, 0);
        offer_segment(-10, -10, 10, 10);
        offer_segment(-10, 5, 10, 5);
        offer_segment(0, -20, 0, 20);
        // An inverted window puts at least one bit of each axis on every point.
        set_window(350, 200, 350, 200);
        offer_segment(275, 275, 275, 275);
        offer_segment(0, 0, 500, 500);
        set_window(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
        offer_segment(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
        set_window(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
        offer_segment(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
        offer_segment(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
    endtask

    task automatic test_random_windows();
        int l;
        int r;
        int b;
        int t;
        int swap;
        for (int k = 0; k < 7; k++)
        begin
            l = random_coord();
            r = random_coord();
            b = random_coord();
            t = random_coord();
            case (k)
                0:
                begin
                    l = WIN_LEFT_RESET;
                    r = WIN_RIGHT_RESET;
                    b = WIN_BOTTOM_RESET;
                    t = WIN_TOP_RESET;
                end
                1:
                begin
                    l = COORD_MIN;
                    r = COORD_MAX;
                    b = COORD_MIN;
                    t = COORD_MAX;
                end
                2:
                begin
                    l = -3;
                    r = 3;
                    b = -3;
                    t = 3;
                end
                3, 4:
                begin
                    if (l > r)
                    begin
                        swap = l;
                        l = r;
                        r = swap;
                    end
                    if (b > t)
                    begin
                        swap = b;
                        b = t;
                        t = swap;
                    end
                end
                5:
                begin
                    if (l < r)
                    begin
                        swap = l;
                        l = r;
                        r = swap;
                    end
                end
                default:
                begin
                    l = 5;
                    r = 5;
                    b = -7;
                    t = -7;
                end
            endcase
            src_idling = (k != 3);
            sink_idling = (k != 4);
            set_window(l, r, b, t);
            random_segments(140, l, r, b, t);
        end
    endtask

    // The receiver stalls long enough that the block fills and refuses requests.
    task automatic test_output_hold_off();
        set_window(-100, 100, -100, 100);
        src_idling = 1'b0;
        sink_idling = 1'b0;
        hold_requests++;
        random_segments(12, -100, 100, -100, 100);
    endtask

    task automatic test_streaming();
        set_window(WIN_LEFT_RESET, WIN_RIGHT_RESET, WIN_BOTTOM_RESET, WIN_TOP_RESET);
        src_idling = 1'b0;
        sink_idling = 1'b0;
        random_segments(150, WIN_LEFT_RESET, WIN_RIGHT_RESET, WIN_BOTTOM_RESET, WIN_TOP_RESET);
    endtask

    // Result receiver: random stall bursts, plus long hold-offs on request.
    initial
    begin
        int stall_left;
        int hold_left;
        int holds_served;
        stall_left = 0;
        hold_left = 0;
        holds_served = 0;
        res_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_served)
            begin
                holds_served = hold_requests;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                res_if.ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                res_if.ready <= 1'b0;
                stall_left--;
            end
            else if (sink_idling && $urandom_range(0, 5) == 0)
            begin
                res_if.ready <= 1'b0;
                stall_left = $urandom_range(0, 8);
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    // Compare every delivered clip with the oldest prediction.
    initial
    begin
        clip_t want;
        clip_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_if.valid && res_if.ready)
            begin
                got.accepted = res_if.accepted;
                got.sx = res_if.clip_start_x;
                got.sy = res_if.clip_start_y;
                got.ex = res_if.clip_end_x;
                got.ey = res_if.clip_end_y;
                if (pending_clips.size() == 0)
                begin
                    failures++;
                    if (failures <= MAX_REPORTS)
                        $display("Unexpected clip result at cycle %0d", cycle_count);
                end
                else
                begin
                    want = pending_clips.pop_front();
                    clips_checked++;
                    if (got.accepted !== want.accepted || got.sx !== want.sx ||
                        got.sy !== want.sy || got.ex !== want.ex || got.ey !== want.ey)
                    begin
                        failures++;
                        if (failures <= MAX_REPORTS)
                            $display("Mismatch at cycle %0d: expected %0b (%0d,%0d)-(%0d,%0d), got %0b (%0d,%0d)-(%0d,%0d)",
                                     cycle_count, want.accepted, want.sx, want.sy, want.ex,
                                     want.ey, got.accepted, got.sx, got.sy, got.ex, got.ey);
                    end
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d clips outstanding", cycle_count,
                 pending_clips.size());
        $display("FAIL line_segment_clipper");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = REG_WIN_LEFT;
        wr_data = '0;
        seg_if.valid = 1'b0;
        seg_if.start_x = '0;
        seg_if.start_y = '0;
        seg_if.end_x = '0;
        seg_if.end_y = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_window();
        test_window_extremes();
        test_random_windows();
        test_output_hold_off();
        test_streaming();

        settle_block();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_clips.size() != 0)
        begin
            $display("%0d predicted clips never arrived", pending_clips.size());
            failures += pending_clips.size();
        end

        $display("Sent %0d segments and checked %0d clips across %0d window settings.",
                 segments_sent, clips_checked, window_settings);
        $display("Covered edge moves on all four sides, degenerate and inverted windows, and output hold-off; %0d failures.",
                 failures);
        if (failures == 0)
            $display("PASS line_segment_clipper");
        else
            $display("FAIL line_segment_clipper");
        $finish;
    end

endmodule
